[hw/rtl/tmam_pkg.sv]
// Shared types and constants of the tiled mirror address map.
// No dependencies; every other file of the block but tmam_div imports this package.
package tmam_pkg;

    // Field widths fixed by the pixel and register formats.
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int FACT_W  = 11;
    localparam int TILE_W  = 12;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Default frame dimension limit.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Register stages from input transaction to output register.
    localparam int POST_STAGES = 3;
    localparam int PIPE_DEPTH  = 1 + DIM_W + COORD_W + POST_STAGES;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIRROR_MODE  = 2'd0,
        REG_TILE_FACTOR  = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_reg_e;

    // Configuration register contents.
    typedef struct packed {
        logic [MODE_W-1:0] mirror_mode;
        logic [FACT_W-1:0] tile_factor;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
    } cfg_t;

    // Per-pixel values set up before the tile divisions.
    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [COORD_W-1:0] coord;
        logic [DIM_W-1:0]   span;
        logic [TILE_W-1:0]  tiles;
        logic               in_frame;
        logic               mode_odd;
        logic               row_axis;
    } prep_t;

    // Values carried through the tile index division.
    typedef struct packed {
        prep_t             prep;
        logic [DIM_W-1:0]  base;
    } stage2_t;

endpackage

[hw/rtl/tiled_mirror_address_map.sv]
// Top level of the tiled mirror address map: configuration registers and the pipeline.
// Depends on tmam_pkg, tmam_prep, tmam_div and tmam_post.
//
// Usage:
//   The slave stream carries destination pixel coordinates, the master stream
//   carries the source coordinate to read and a flag telling whether the pixel
//   takes a mirrored value. Each input transaction yields exactly one output
//   transaction, in order.
//   The configuration channel writes mirror mode, tile factor, frame width and
//   frame height by index; write it only while the pipeline is empty.
//   Throughput is one pixel per clock unless the receiver stalls. An accepted input
//   transaction passes through one setup stage, 13 stages of the tile size divider,
//   12 stages of the tile index divider and three back-end stages. Each stage holds
//   its data while the next stage is full, so bubbles are squeezed out and input is
//   still taken while a result waits at the output; input stalls only when all 29
//   stages are occupied and the receiver stalls.
//   Reset empties the pipeline and loads mode 1, factor 1 and a 640 x 480 frame.
module tiled_mirror_address_map #(
    parameter int MAX_DIM = tmam_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmam_pkg::DIM_W-1:0]     cfg_data,
    // Pixel input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // pix_x[11:0], pix_y[23:12]
    // Source coordinate output stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // src_x[11:0], src_y[23:12]
    output logic                           m_axis_tuser   // overwritten
);
    import tmam_pkg::*;

    cfg_t               cfg_reg;
    logic               prep_valid;
    logic               prep_ready;
    prep_t              prep_data;
    logic               div1_valid;
    logic               div1_ready;
    logic [DIM_W-1:0]   div1_quot;
    logic [$bits(prep_t)-1:0]   div1_side;
    stage2_t            s2_in;
    logic               div2_valid;
    logic               div2_ready;
    logic [COORD_W-1:0] div2_quot;
    logic [$bits(stage2_t)-1:0] div2_side;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mirror_mode  <= MODE_W'(1);
            cfg_reg.tile_factor  <= FACT_W'(1);
            cfg_reg.frame_width  <= DIM_W'(640);
            cfg_reg.frame_height <= DIM_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIRROR_MODE:  cfg_reg.mirror_mode  <= cfg_data[MODE_W-1:0];
                REG_TILE_FACTOR:  cfg_reg.tile_factor  <= cfg_data[FACT_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // Axis choice and tile count.
    tmam_prep #(
        .MAX_DIM(MAX_DIM)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .pix_x    (s_axis_tdata[11:0]),
        .pix_y    (s_axis_tdata[23:12]),
        .out_valid(prep_valid),
        .out_ready(prep_ready),
        .out_prep (prep_data)
    );

    // Tile base size: span divided by tile count.
    tmam_div #(
        .NW(DIM_W),
        .DW(TILE_W),
        .SW($bits(prep_t))
    ) u_div_base (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_dividend(prep_data.span),
        .in_divisor (prep_data.tiles),
        .in_side    (prep_data),
        .out_valid  (div1_valid),
        .out_ready  (div1_ready),
        .out_quot   (div1_quot),
        .out_side   (div1_side)
    );

    assign s2_in.prep = prep_t'(div1_side);
    assign s2_in.base = div1_quot;

    // Tile index: coordinate divided by base size.
    tmam_div #(
        .NW(COORD_W),
        .DW(DIM_W),
        .SW($bits(stage2_t))
    ) u_div_tile (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div1_valid),
        .in_ready   (div1_ready),
        .in_dividend(s2_in.prep.coord),
        .in_divisor (s2_in.base),
        .in_side    (s2_in),
        .out_valid  (div2_valid),
        .out_ready  (div2_ready),
        .out_quot   (div2_quot),
        .out_side   (div2_side)
    );

    // Mirror arithmetic and output register.
    tmam_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div2_valid),
        .in_ready   (div2_ready),
        .in_tile    (div2_quot),
        .in_data    (stage2_t'(div2_side)),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .src_x      (src_x),
        .src_y      (src_y),
        .overwritten(m_axis_tuser)
    );

    assign m_axis_tdata = {src_y, src_x};

endmodule

[hw/rtl/tmam_prep.sv]
// Entry stage: saturates the frame size, picks the mirror axis and clamps the tile count.
// Depends on tmam_pkg.
module tmam_prep #(
    parameter int MAX_DIM = tmam_pkg::MAX_DIM_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmam_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tmam_pkg::COORD_W-1:0] pix_x,
    input  logic [tmam_pkg::COORD_W-1:0] pix_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tmam_pkg::prep_t              out_prep
);
    import tmam_pkg::*;

    logic              valid_reg;
    prep_t             prep_reg;
    prep_t             prep_next;
    logic [DIM_W-1:0]  w_sat;
    logic [DIM_W-1:0]  h_sat;
    logic [DIM_W-1:0]  span;
    logic [DIM_W-1:0]  half_span;
    logic [DIM_W-1:0]  factor_lim;
    logic [DIM_W-1:0]  factor_ext;
    logic [DIM_W-1:0]  factor_cl;

    // Frame dimensions above the limit are saturated.
    assign w_sat = (int'(cfg.frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.frame_width;
    assign h_sat = (int'(cfg.frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.frame_height;

    // Axis selection and tile count clamp to half the span.
    assign span       = cfg.mirror_mode[1] ? h_sat : w_sat;
    assign half_span  = span >> 1;
    assign factor_lim = (half_span == '0) ? '0 : half_span - DIM_W'(1);
    assign factor_ext = DIM_W'(cfg.tile_factor);
    assign factor_cl  = (factor_ext > factor_lim) ? factor_lim : factor_ext;

    always_comb
    begin
        prep_next.pix_x    = pix_x;
        prep_next.pix_y    = pix_y;
        prep_next.coord    = cfg.mirror_mode[1] ? pix_y : pix_x;
        prep_next.span     = span;
        prep_next.tiles    = TILE_W'(factor_cl + DIM_W'(1));
        prep_next.in_frame = (DIM_W'(pix_x) < w_sat) && (DIM_W'(pix_y) < h_sat);
        prep_next.mode_odd = cfg.mirror_mode[0];
        prep_next.row_axis = cfg.mirror_mode[1];
    end

    assign in_ready = !valid_reg || out_ready;

    // Valid flag of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (in_ready)
            prep_reg <= prep_next;
    end

    assign out_valid = valid_reg;
    assign out_prep  = prep_reg;

endmodule

[hw/rtl/tmam_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with a sideband word.
// No package dependencies.
module tmam_div #(
    parameter int NW = 13,
    parameter int DW = 12,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] in_dividend,
    input  logic [DW-1:0] in_divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [NW-1:0] out_quot,
    output logic [SW-1:0] out_side
);

    // Stage registers; slot k of the st_* arrays is the input of stage k.
    logic          valid_reg [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [NW-1:0] dq_reg    [NW];
    logic [DW-1:0] dvs_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    logic          st_valid [NW+1];
    logic [DW-1:0] st_rem   [NW+1];
    logic [NW-1:0] st_dq    [NW+1];
    logic [DW-1:0] st_dvs   [NW+1];
    logic [SW-1:0] st_side  [NW+1];

    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] dq_next  [NW];
    logic [NW:0]   rdy;

    assign st_valid[0] = in_valid;
    assign st_rem[0]   = '0;
    assign st_dq[0]    = in_dividend;
    assign st_dvs[0]   = in_divisor;
    assign st_side[0]  = in_side;
    assign rdy[NW]     = out_ready;

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        // One restoring step: shift in the next dividend bit and try a subtract.
        assign trial = {st_rem[k], st_dq[k][NW-1]};
        assign ge    = trial >= {1'b0, st_dvs[k]};
        assign diff  = trial - {1'b0, st_dvs[k]};
        assign rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign dq_next[k]  = {st_dq[k][NW-2:0], ge};

        // A stage takes new data when it is empty or its successor moves.
        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= st_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next[k];
                dq_reg[k]   <= dq_next[k];
                dvs_reg[k]  <= st_dvs[k];
                side_reg[k] <= st_side[k];
            end
        end

        assign st_valid[k+1] = valid_reg[k];
        assign st_rem[k+1]   = rem_reg[k];
        assign st_dq[k+1]    = dq_reg[k];
        assign st_dvs[k+1]   = dvs_reg[k];
        assign st_side[k+1]  = side_reg[k];
    end

    assign in_ready  = rdy[0];
    assign out_valid = st_valid[NW];
    assign out_quot  = st_dq[NW];
    assign out_side  = st_side[NW];

endmodule

[hw/rtl/tmam_post.sv]
// Back end: tile offset and size, mirror test and source coordinate, in three stages.
// Depends on tmam_pkg.
module tmam_post (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tmam_pkg::TILE_W-1:0]  in_tile,
    input  tmam_pkg::stage2_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tmam_pkg::COORD_W-1:0] src_x,
    output logic [tmam_pkg::COORD_W-1:0] src_y,
    output logic                         overwritten
);
    import tmam_pkg::*;

    localparam int PROD_W = TILE_W + DIM_W;

    // Stage A: clamped tile index and tile offset.
    logic              a_valid_reg;
    prep_t             a_prep_reg;
    logic [DIM_W-1:0]  a_base_reg;
    logic [DIM_W-1:0]  a_off_reg;
    logic              a_last_reg;
    logic [TILE_W-1:0] tiles_m1;
    logic [TILE_W-1:0] tile_cl;
    logic [PROD_W-1:0] prod;

    // Stage B: tile size and local coordinate.
    logic              b_valid_reg;
    prep_t             b_prep_reg;
    logic [DIM_W-1:0]  b_off_reg;
    logic [DIM_W-1:0]  b_w_reg;
    logic [DIM_W-1:0]  b_local_reg;
    logic [DIM_W-1:0]  w_next;
    logic [DIM_W-1:0]  local_next;

    // Stage C: output register.
    logic               c_valid_reg;
    logic [COORD_W-1:0] src_x_reg;
    logic [COORD_W-1:0] src_y_reg;
    logic               hit_reg;
    logic [DIM_W-1:0]   half;
    logic               hit_raw;
    logic               hit_next;
    logic [DIM_W-1:0]   mirrored;

    logic rdy_a;
    logic rdy_b;
    logic rdy_c;

    assign rdy_c    = !c_valid_reg || out_ready;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign in_ready = rdy_a;

    // The last tile absorbs any index past it.
    assign tiles_m1 = in_data.prep.tiles - TILE_W'(1);
    assign tile_cl  = (in_tile > tiles_m1) ? tiles_m1 : in_tile;
    assign prod     = PROD_W'(tile_cl) * PROD_W'(in_data.base);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (rdy_a)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_prep_reg <= in_data.prep;
            a_base_reg <= in_data.base;
            a_off_reg  <= prod[DIM_W-1:0];
            a_last_reg <= (tile_cl == tiles_m1);
        end
    end

    // The last tile takes the remainder of the span.
    assign w_next     = a_last_reg ? (a_prep_reg.span - a_off_reg) : a_base_reg;
    assign local_next = DIM_W'(a_prep_reg.coord) - a_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (rdy_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b)
        begin
            b_prep_reg  <= a_prep_reg;
            b_off_reg   <= a_off_reg;
            b_w_reg     <= w_next;
            b_local_reg <= local_next;
        end
    end

    // Mirror test within the tile and the reflected coordinate.
    assign half     = b_w_reg >> 1;
    assign hit_raw  = b_prep_reg.mode_odd ? (b_local_reg < half)
                                          : (b_local_reg >= (b_w_reg - half));
    assign hit_next = hit_raw && b_prep_reg.in_frame;
    assign mirrored = b_off_reg + (b_w_reg - DIM_W'(1) - b_local_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (rdy_c)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c)
        begin
            src_x_reg <= (hit_next && !b_prep_reg.row_axis) ? mirrored[COORD_W-1:0]
                                                           : b_prep_reg.pix_x;
            src_y_reg <= (hit_next && b_prep_reg.row_axis) ? mirrored[COORD_W-1:0]
                                                          : b_prep_reg.pix_y;
            hit_reg   <= hit_next;
        end
    end

    assign out_valid   = c_valid_reg;
    assign src_x       = src_x_reg;
    assign src_y       = src_y_reg;
    assign overwritten = hit_reg;

endmodule

[hw/rtl/tmam_checker.sv]
// Port-level checks of the tiled mirror address map, bound to the top level.
// Depends on tmam_pkg and tiled_mirror_address_map.
module tmam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import tmam_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;

    // Transactions accepted but not yet delivered.
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + CNT_W'(1);
        else if (out_acc && !in_acc)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // No result appears without an outstanding input.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count_reg != '0)
        else $error("output valid with no transaction in flight");

    // Input backpressure only when the receiver stalls a result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the output is free");

    // Input backpressure only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> count_reg == CNT_W'(PIPE_DEPTH))
        else $error("input stalled with empty pipeline stages");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output changed");

endmodule

bind tiled_mirror_address_map tmam_checker u_checker (.*);
